// File: hdl/bfso_pkg.sv
// Shared types, constants and the arctangent table for the bearing block.
package bfso_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int COORD_BITS   = 12;
    localparam int GUARD_BITS   = 20;
    localparam int TABLE_LEN    = 24;
    localparam int STEP_W       = $clog2(TABLE_LEN);

    // x only grows by the CORDIC gain times the vector length, so three bits of
    // headroom above the guarded magnitude are enough; y carries a sign on top.
    localparam int X_W   = COORD_BITS + GUARD_BITS + 3;
    localparam int Y_W   = X_W + 1;
    localparam int ANG_W = 26;
    localparam int OUT_W = 17;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_Y = CFG_IDX_W'(1);
    localparam logic [COORD_BITS-1:0] OWN_RESET = COORD_BITS'(2048);

    // Angles are held in units of 2^-16 degree.
    localparam logic signed [ANG_W-1:0] ANG_QUARTER = ANG_W'(90 * 65536);
    localparam logic signed [ANG_W-1:0] ANG_THREE_Q = ANG_W'(270 * 65536);
    localparam logic [OUT_W:0]           FULL_TURN   = (OUT_W + 1)'(92160);
    localparam logic [OUT_W-1:0]         HALF_TURN   = OUT_W'(46080);
    localparam logic [ANG_W-1:0]         ROUND_HALF  = ANG_W'(128);

    typedef struct packed {
        logic [X_W-1:0]          x;
        logic signed [Y_W-1:0]   y;
        logic signed [ANG_W-1:0] z;
        logic                    dx_zero;
        logic                    dx_pos;
        logic                    dy_neg;
        logic                    negate;
    } t_cordic;

    // atan(2^-i) in 2^-16 degree, rounded to nearest.
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = ANG_W'(2949120);
            5'd1:    v = ANG_W'(1740967);
            5'd2:    v = ANG_W'(919879);
            5'd3:    v = ANG_W'(466945);
            5'd4:    v = ANG_W'(234379);
            5'd5:    v = ANG_W'(117304);
            5'd6:    v = ANG_W'(58666);
            5'd7:    v = ANG_W'(29335);
            5'd8:    v = ANG_W'(14668);
            5'd9:    v = ANG_W'(7334);
            5'd10:   v = ANG_W'(3667);
            5'd11:   v = ANG_W'(1833);
            5'd12:   v = ANG_W'(917);
            5'd13:   v = ANG_W'(458);
            5'd14:   v = ANG_W'(229);
            5'd15:   v = ANG_W'(115);
            5'd16:   v = ANG_W'(57);
            5'd17:   v = ANG_W'(29);
            5'd18:   v = ANG_W'(14);
            5'd19:   v = ANG_W'(7);
            5'd20:   v = ANG_W'(4);
            5'd21:   v = ANG_W'(2);
            5'd22:   v = ANG_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/bearing_from_screen_offset.sv
// Bearing of a screen target from the ownship centre, built as a row of CORDIC cells.
// Accepts one target position per clock while o_stall is low and returns one bearing
// per item, in 1/256 degree, measured as a compass bearing from the configured ownship
// centre. The pipeline is one entry stage, 16 CORDIC cells (one rotation each) and one
// output register. Every stage has its own valid bit, so items keep moving into empty
// stages while a finished bearing waits at the output; input is held off only once
// every stage is full. Ownship x and y are written through the configuration port,
// index 0 and 1, and reset to 2048.
module bearing_from_screen_offset (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [11:0]                         i_target_x,
    input  logic [11:0]                         i_target_y,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [16:0]                         o_bearing,
    input  logic                                i_cfg_we,
    input  logic [bfso_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [11:0]                         i_cfg_data
);

    logic [bfso_pkg::COORD_BITS-1:0] r_own_x;
    logic [bfso_pkg::COORD_BITS-1:0] r_own_y;
    bfso_pkg::t_cordic               stage_data [0:bfso_pkg::CORDIC_STEPS];
    logic                            stage_valid [0:bfso_pkg::CORDIC_STEPS];
    logic                            stage_ready [0:bfso_pkg::CORDIC_STEPS];
    logic                            front_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_x <= bfso_pkg::OWN_RESET;
            r_own_y <= bfso_pkg::OWN_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == bfso_pkg::CFG_OWN_X) begin
                r_own_x <= i_cfg_data[bfso_pkg::COORD_BITS-1:0];
            end else if (i_cfg_index == bfso_pkg::CFG_OWN_Y) begin
                r_own_y <= i_cfg_data[bfso_pkg::COORD_BITS-1:0];
            end
        end
    end

    bfso_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (front_ready),
        .i_target_x (i_target_x[bfso_pkg::COORD_BITS-1:0]),
        .i_target_y (i_target_y[bfso_pkg::COORD_BITS-1:0]),
        .i_own_x    (r_own_x),
        .i_own_y    (r_own_y),
        .o_valid    (stage_valid[0]),
        .i_ready    (stage_ready[0]),
        .o_data     (stage_data[0])
    );

    assign o_stall = !front_ready;

    for (genvar k = 0; k < bfso_pkg::CORDIC_STEPS; k++) begin : g_cell
        bfso_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (bfso_pkg::STEP_W'(k)),
            .i_valid (stage_valid[k]),
            .o_ready (stage_ready[k]),
            .i_data  (stage_data[k]),
            .o_valid (stage_valid[k+1]),
            .i_ready (stage_ready[k+1]),
            .o_data  (stage_data[k+1])
        );
    end

    bfso_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (stage_valid[bfso_pkg::CORDIC_STEPS]),
        .o_ready   (stage_ready[bfso_pkg::CORDIC_STEPS]),
        .i_data    (stage_data[bfso_pkg::CORDIC_STEPS]),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_bearing (o_bearing)
    );

endmodule

// File: hdl/bfso_front.sv
// Entry stage: offsets against the ownship centre, quadrant flags, CORDIC start vector.
module bfso_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [bfso_pkg::COORD_BITS-1:0] i_target_x,
    input  logic [bfso_pkg::COORD_BITS-1:0] i_target_y,
    input  logic [bfso_pkg::COORD_BITS-1:0] i_own_x,
    input  logic [bfso_pkg::COORD_BITS-1:0] i_own_y,
    output logic                            o_valid,
    input  logic                            i_ready,
    output bfso_pkg::t_cordic               o_data
);

    logic signed [bfso_pkg::COORD_BITS:0] dx;
    logic signed [bfso_pkg::COORD_BITS:0] dy;
    logic [bfso_pkg::COORD_BITS:0]        dx_abs;
    logic [bfso_pkg::COORD_BITS:0]        dy_abs;
    logic                                 r_valid;
    bfso_pkg::t_cordic                    r_data;
    bfso_pkg::t_cordic                    n_data;

    assign dx     = $signed({1'b0, i_target_x}) - $signed({1'b0, i_own_x});
    assign dy     = $signed({1'b0, i_target_y}) - $signed({1'b0, i_own_y});
    assign dx_abs = dx[bfso_pkg::COORD_BITS] ? $unsigned(-dx) : $unsigned(dx);
    assign dy_abs = dy[bfso_pkg::COORD_BITS] ? $unsigned(-dy) : $unsigned(dy);

    always_comb begin
        n_data.x = bfso_pkg::X_W'(dx_abs[bfso_pkg::COORD_BITS-1:0]) << bfso_pkg::GUARD_BITS;
        n_data.y = $signed(bfso_pkg::Y_W'(dy_abs[bfso_pkg::COORD_BITS-1:0])
                           << bfso_pkg::GUARD_BITS);
        n_data.z       = '0;
        n_data.dx_zero = (dx == '0);
        n_data.dx_pos  = !dx[bfso_pkg::COORD_BITS] && (dx != '0);
        n_data.dy_neg  = dy[bfso_pkg::COORD_BITS];
        n_data.negate  = (dx[bfso_pkg::COORD_BITS] != dy[bfso_pkg::COORD_BITS]) && (dy != '0);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: hdl/bfso_cell.sv
// One vectoring CORDIC rotation, registered, with its own item valid bit.
module bfso_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [bfso_pkg::STEP_W-1:0]      i_step,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  bfso_pkg::t_cordic                i_data,
    output logic                             o_valid,
    input  logic                             i_ready,
    output bfso_pkg::t_cordic                o_data
);

    logic [bfso_pkg::Y_W-1:0]           y_mag;
    logic [bfso_pkg::X_W-1:0]           x_shift;
    logic [bfso_pkg::X_W-1:0]           y_shift;
    logic signed [bfso_pkg::ANG_W-1:0]  step_ang;
    logic                               r_valid;
    bfso_pkg::t_cordic                  r_data;
    bfso_pkg::t_cordic                  n_data;

    // Magnitudes are shifted, so a negative y truncates toward zero.
    assign y_mag    = i_data.y[bfso_pkg::Y_W-1] ? bfso_pkg::Y_W'(-i_data.y)
                                                : bfso_pkg::Y_W'(i_data.y);
    assign x_shift  = i_data.x >> i_step;
    assign y_shift  = bfso_pkg::X_W'(y_mag >> i_step);
    assign step_ang = bfso_pkg::atan_entry(i_step);

    always_comb begin
        n_data   = i_data;
        n_data.x = i_data.x + y_shift;
        if (!i_data.y[bfso_pkg::Y_W-1]) begin
            n_data.y = i_data.y - $signed({1'b0, x_shift});
            n_data.z = i_data.z + step_ang;
        end else begin
            n_data.y = i_data.y + $signed({1'b0, x_shift});
            n_data.z = i_data.z - step_ang;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: hdl/bfso_back.sv
// Output stage: clamp, quadrant fold to a compass bearing, rounding and wrap.
module bfso_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  bfso_pkg::t_cordic             i_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bfso_pkg::OUT_W-1:0]    o_bearing
);

    logic signed [bfso_pkg::ANG_W-1:0] z_clamp;
    logic signed [bfso_pkg::ANG_W-1:0] ang;
    logic signed [bfso_pkg::ANG_W-1:0] base;
    logic [bfso_pkg::ANG_W-1:0]        full;
    logic [bfso_pkg::ANG_W-1:0]        rnd;
    logic [bfso_pkg::OUT_W:0]          coarse;
    logic [bfso_pkg::OUT_W:0]          wrapped;
    logic [bfso_pkg::OUT_W-1:0]        n_bearing;
    logic                              r_valid;
    logic [bfso_pkg::OUT_W-1:0]        r_bearing;

    always_comb begin
        if (i_data.z < 0) begin
            z_clamp = '0;
        end else if (i_data.z > bfso_pkg::ANG_QUARTER) begin
            z_clamp = bfso_pkg::ANG_QUARTER;
        end else begin
            z_clamp = i_data.z;
        end
    end

    assign ang     = i_data.negate ? -z_clamp : z_clamp;
    assign base    = i_data.dx_pos ? bfso_pkg::ANG_THREE_Q : bfso_pkg::ANG_QUARTER;
    assign full    = bfso_pkg::ANG_W'(base + ang);
    assign rnd     = full + bfso_pkg::ROUND_HALF;
    assign coarse  = rnd[bfso_pkg::ANG_W-1:8];
    assign wrapped = (coarse >= bfso_pkg::FULL_TURN) ? coarse - bfso_pkg::FULL_TURN : coarse;

    always_comb begin
        if (i_data.dx_zero) begin
            n_bearing = i_data.dy_neg ? bfso_pkg::HALF_TURN : '0;
        end else begin
            n_bearing = wrapped[bfso_pkg::OUT_W-1:0];
        end
    end

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bearing <= n_bearing;
        end
    end

    assign o_valid   = r_valid;
    assign o_bearing = r_bearing;

endmodule

// File: hdl/bfso_checker.sv
// Port-level checks for the bearing block, bound to its top level.
module bfso_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           o_stall,
    input  logic [11:0]                    i_target_x,
    input  logic [11:0]                    i_target_y,
    input  logic                           o_valid,
    input  logic                           i_stall,
    input  logic [16:0]                    o_bearing,
    input  logic                           i_cfg_we,
    input  logic [bfso_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [11:0]                    i_cfg_data
);

    // The pipeline is cleared by reset, so no item can show the cycle after it.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("item shown right after reset");

    // Input is only held off when the whole row is full and the output waits.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled with room in the pipeline");

    a_bearing_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bearing < 17'd92160))
        else $error("bearing at or beyond a full turn");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_bearing)))
        else $error("stalled item changed or dropped");

endmodule

bind bearing_from_screen_offset bfso_checker u_bfso_checker (.*);
